// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files that check their own logic.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SWM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/swmax_pkg.sv -----
package swmax_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;

    // Operations broadcast to every cell of the chain.
    localparam logic [1:0] OP_HOLD  = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_SHIFT = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] window_max;
        logic                       last_result;
    } t_out;

    // Control shared by all cells in one cycle.
    typedef struct packed {
        logic [1:0]                 op;
        logic                       drop;
        logic signed [SAMPLE_W-1:0] sample;
    } t_cell_ctl;

endpackage

// ----- rtl/swmax_cell.sv -----
module swmax_cell import swmax_pkg::*; #(
    parameter int AGE_W = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctl                  i_ctl,
    input  logic                       i_head,
    input  logic                       i_prev_kept,
    input  logic signed [SAMPLE_W-1:0] i_next_value,
    input  logic [AGE_W-1:0]           i_next_age,
    input  logic                       i_next_valid,
    input  logic                       i_next_kept,
    output logic signed [SAMPLE_W-1:0] o_value,
    output logic [AGE_W-1:0]           o_age,
    output logic                       o_valid,
    output logic                       o_kept
);

    logic signed [SAMPLE_W-1:0] r_value;
    logic signed [SAMPLE_W-1:0] n_value;
    logic [AGE_W-1:0]           r_age;
    logic [AGE_W-1:0]           n_age;
    logic                       r_valid;
    logic                       n_valid;
    logic                       w_kept;

    // A candidate survives the new sample unless it is strictly smaller.
    assign w_kept = r_valid && (r_value >= i_ctl.sample);

    // Next contents: keep, take the neighbour's entry, take the new sample or empty.
    always_comb begin
        n_value = r_value;
        n_age   = r_age;
        n_valid = r_valid;
        unique case (i_ctl.op)
            OP_HOLD: begin
                n_valid = r_valid;
            end
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            OP_SHIFT: begin
                n_value = i_next_value;
                n_age   = i_next_age;
                n_valid = i_next_valid;
            end
            OP_STEP: begin
                if (!i_ctl.drop) begin
                    if (w_kept) begin
                        n_age = r_age + AGE_W'(1);
                    end else if (i_prev_kept || i_head) begin
                        n_value = i_ctl.sample;
                        n_age   = '0;
                        n_valid = 1'b1;
                    end else begin
                        n_valid = 1'b0;
                    end
                end else begin
                    if (i_next_kept) begin
                        n_value = i_next_value;
                        n_age   = i_next_age + AGE_W'(1);
                        n_valid = 1'b1;
                    end else if (w_kept || i_head) begin
                        n_value = i_ctl.sample;
                        n_age   = '0;
                        n_valid = 1'b1;
                    end else begin
                        n_valid = 1'b0;
                    end
                end
            end
        endcase
    end

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Candidate payload.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign o_value = r_value;
    assign o_age   = r_age;
    assign o_valid = r_valid;
    assign o_kept  = w_kept;

endmodule

// ----- rtl/sliding_window_maximum.sv -----
// Sliding-window maximum over a stream of signed 32-bit samples. A row of WINDOW_MAX cells
// holds the candidate queue, front in cell 0; every cell compares its candidate with the new
// sample in the same cycle and takes its own, its right neighbour's or the new entry, so one
// sample is accepted per clock while input ready is high and its result is registered. A result
// appears once window_size samples of the current sequence have arrived; a sample marked last
// empties the queue. Input ready is low while the output register is full and not taken, and
// after a window_size write while candidates outside the new window leave the front cell, one
// per cycle; the configuration channel itself is always ready.
`include "assert_macros.svh"

module sliding_window_maximum import swmax_pkg::*; #(
    parameter int WINDOW_MAX = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data
);

    localparam int SEEN_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (SEEN_W > CFG_W) ? SEEN_W : CFG_W;

    logic [CFG_W-1:0]           r_window;
    logic [SEEN_W-1:0]          r_seen;
    logic [SEEN_W-1:0]          n_seen;
    logic                       r_trim;
    logic                       n_trim;
    logic                       r_out_valid;
    logic                       n_out_valid;
    t_out                       r_out;

    logic                       w_cfg_xfer;
    logic                       w_in_xfer;
    logic [CMP_W-1:0]           w_eff;
    logic [CMP_W-1:0]           w_eff_m1;
    logic                       w_drop;
    logic [SEEN_W-1:0]          w_seen_inc;
    logic                       w_emit;
    logic signed [SAMPLE_W-1:0] w_front;
    t_cell_ctl                  w_ctl;

    // Cell outputs, padded with an empty entry past the last cell.
    logic signed [SAMPLE_W-1:0] c_value [WINDOW_MAX+1];
    logic [SEEN_W-1:0]          c_age   [WINDOW_MAX+1];
    logic                       c_valid [WINDOW_MAX+1];
    logic                       c_kept  [WINDOW_MAX+1];
    logic                       c_prev  [WINDOW_MAX];

    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_trim && (!r_out_valid || i_out_ready);

    // Effective window: zero counts as one, large values saturate at the cell count.
    always_comb begin
        if (r_window == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(r_window) > CMP_W'(WINDOW_MAX)) begin
            w_eff = CMP_W'(WINDOW_MAX);
        end else begin
            w_eff = CMP_W'(r_window);
        end
    end
    assign w_eff_m1 = w_eff - CMP_W'(1);

    // The front candidate leaves the window once it has aged to window minus one.
    assign w_drop = c_valid[0] && (CMP_W'(c_age[0]) >= w_eff_m1);

    // Broadcast control for the cell row.
    always_comb begin
        w_ctl.sample = i_in_data.sample;
        w_ctl.drop   = w_drop;
        priority if (w_in_xfer) begin
            w_ctl.op = i_in_data.last_sample ? OP_CLEAR : OP_STEP;
        end else if (r_trim && w_drop) begin
            w_ctl.op = OP_SHIFT;
        end else begin
            w_ctl.op = OP_HOLD;
        end
    end

    // The row of cells.
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign c_prev[g] = 1'b0;
        end else begin : g_rest
            assign c_prev[g] = c_kept[g-1];
        end

        swmax_cell #(
            .AGE_W (SEEN_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_head       (g == 0),
            .i_prev_kept  (c_prev[g]),
            .i_next_value (c_value[g+1]),
            .i_next_age   (c_age[g+1]),
            .i_next_valid (c_valid[g+1]),
            .i_next_kept  (c_kept[g+1]),
            .o_value      (c_value[g]),
            .o_age        (c_age[g]),
            .o_valid      (c_valid[g]),
            .o_kept       (c_kept[g])
        );
    end

    assign c_value[WINDOW_MAX] = '0;
    assign c_age[WINDOW_MAX]   = '0;
    assign c_valid[WINDOW_MAX] = 1'b0;
    assign c_kept[WINDOW_MAX]  = 1'b0;

    // Front of the queue after this sample has been taken in.
    always_comb begin
        if (w_drop) begin
            w_front = c_kept[1] ? c_value[1] : i_in_data.sample;
        end else begin
            w_front = c_kept[0] ? c_value[0] : i_in_data.sample;
        end
    end

    // Sample count of the current sequence, saturating.
    assign w_seen_inc = (r_seen == SEEN_W'(WINDOW_MAX)) ? r_seen : r_seen + SEEN_W'(1);
    assign w_emit     = CMP_W'(w_seen_inc) >= w_eff;

    always_comb begin
        n_seen = r_seen;
        if (w_in_xfer) begin
            n_seen = i_in_data.last_sample ? '0 : w_seen_inc;
        end
    end

    // Trimming runs after every window write until the front is inside the window.
    always_comb begin
        n_trim = r_trim;
        if (w_cfg_xfer) begin
            n_trim = 1'b1;
        end else if (r_trim && !w_drop) begin
            n_trim = 1'b0;
        end
    end

    // Output register: filled by an emitting sample, emptied by a transfer.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_in_xfer && w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= CFG_W'(1);
            r_seen      <= '0;
            r_trim      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_xfer) begin
                r_window <= i_cfg_data;
            end
            r_seen      <= n_seen;
            r_trim      <= n_trim;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_emit) begin
            r_out.window_max  <= w_front;
            r_out.last_result <= i_in_data.last_sample;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Self-checks on the queue.
    `SWM_ASSERT(a_packed, !c_valid[1] || c_valid[0], "candidate queue is not packed at the front")
    `SWM_ASSERT_IMPL(a_order, c_valid[1], c_value[0] >= c_value[1], "front is not the largest")
    `SWM_ASSERT_NEXT(a_clear, w_in_xfer && i_in_data.last_sample, !c_valid[0], "queue not cleared")
    `SWM_ASSERT_NEXT(a_fill, w_in_xfer && !i_in_data.last_sample, c_valid[0], "queue empty after sample")

endmodule

// ----- bench/sliding_window_maximum_test.sv -----
module sliding_window_maximum_test;

    import swmax_pkg::*;

    localparam int WIN_MAX      = 64;
    localparam int RANDOM_ITEMS = 1800;
    localparam int STALL_LIMIT  = 2000;

    // One retained candidate: its value and its age in samples.
    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        int unsigned                age;
    } t_cand;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in              i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out             o_out_data;

    // Predicted state of the block.
    t_cand            candidates[$];
    logic [CFG_W-1:0] window_reg = 7'd1;
    int unsigned      seq_count  = 0;

    t_out        expected_max_q[$];
    int          fail_count  = 0;
    int          random_sent = 0;
    int unsigned idle_max    = 8;
    int unsigned out_stall   = 0;
    int          quiet_cycles = 0;

    sliding_window_maximum #(
        .WINDOW_MAX (WIN_MAX)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // A window code of zero means one sample; codes above the depth saturate.
    function automatic int unsigned eff_window(input logic [CFG_W-1:0] code);
        if (code == '0) begin
            return 1;
        end
        if (32'(code) > WIN_MAX) begin
            return WIN_MAX;
        end
        return 32'(code);
    endfunction

    // Advances the candidate queue by one sample and queues the maximum it yields, if any.
    function automatic void predict_window_max(input t_in item);
        int unsigned w;
        t_cand       kept[$];
        t_cand       c;
        t_out        res;
        w = eff_window(window_reg);
        // Age every candidate and keep only those still inside the window.
        foreach (candidates[i]) begin
            if (candidates[i].age + 1 < w) begin
                c.value = candidates[i].value;
                c.age   = candidates[i].age + 1;
                kept.insert(kept.size(), c);
            end
        end
        // Strictly smaller candidates at the back can never be the maximum again.
        while (kept.size() > 0 && kept[$].value < item.sample) begin
            kept.delete(kept.size() - 1);
        end
        if (kept.size() >= WIN_MAX) begin
            kept.delete(0);
        end
        c.value = item.sample;
        c.age   = 0;
        kept.insert(kept.size(), c);
        candidates = kept;
        if (seq_count < WIN_MAX) begin
            seq_count++;
        end
        if (seq_count >= w) begin
            res.window_max  = kept[0].value;
            res.last_result = item.last_sample;
            expected_max_q.insert(expected_max_q.size(), res);
        end
        // The final sample of a sequence empties the queue and the count.
        if (item.last_sample) begin
            candidates.delete();
            seq_count = 0;
        end
    endfunction

    // Compares one accepted result with the oldest outstanding prediction.
    function automatic void check_result(input t_out got);
        t_out want;
        if (expected_max_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual window_max=%0d %s%0b",
                     $time, got.window_max, "last_result=", got.last_result);
            fail_count++;
        end else begin
            want = expected_max_q[0];
            expected_max_q.delete(0);
            if (got.window_max !== want.window_max) begin
                $display("%0t: window_max mismatch: expected %0d, actual %0d",
                         $time, want.window_max, got.window_max);
                fail_count++;
            end
            if (got.last_result !== want.last_result) begin
                $display("%0t: last_result mismatch: expected %0b, actual %0b",
                         $time, want.last_result, got.last_result);
                fail_count++;
            end
        end
    endfunction

    // Result side: check each transfer, then stall for a freshly drawn number of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_result(o_out_data);
            out_stall = $urandom_range(0, idle_max);
        end else if (out_stall != 0) begin
            out_stall--;
        end
        i_out_ready <= (out_stall == 0);
    end

    // Watchdog: too many cycles without any transfer on any channel ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Sends one sample after a random gap and predicts its result once it is transferred.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        int unsigned gap;
        t_in         item;
        item.sample      = value;
        item.last_sample = last;
        gap = $urandom_range(0, idle_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_window_max(item);
    endtask

    // Holds the input back until every predicted result has been transferred.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (expected_max_q.size() != 0) @(posedge i_clk);
        // A sample without a result may still be in flight.
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] code);
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= code;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        window_reg = code;
    endtask

    // Window of one straight after reset, with the extreme sample values.
    task automatic test_reset_window();
        send_sample(32'sh7FFFFFFF, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b1);
    endtask

    // Equal values must not displace one another.
    task automatic test_equal_values();
        write_window(7'd3);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(2, 1'b0);
        send_sample(5, 1'b0);
        send_sample(-7, 1'b0);
        send_sample(-7, 1'b0);
        send_sample(9, 1'b1);
    endtask

    // A sequence shorter than the window yields nothing but still clears the state.
    task automatic test_short_sequence();
        write_window(7'd5);
        send_sample(10, 1'b0);
        send_sample(-10, 1'b0);
        send_sample(3, 1'b1);
    endtask

    // Window code zero acts as one; codes above the depth saturate.
    task automatic test_window_limits();
        write_window(7'd0);
        send_sample(-4, 1'b0);
        send_sample(8, 1'b1);
        write_window(7'd127);
        send_sample(1, 1'b0);
        send_sample(2, 1'b1);
    endtask

    // Shrinking the window part-way through a sequence.
    task automatic test_resize_midsequence();
        write_window(7'd4);
        send_sample(9, 1'b0);
        send_sample(1, 1'b0);
        send_sample(2, 1'b0);
        send_sample(3, 1'b0);
        send_sample(4, 1'b0);
        write_window(7'd2);
        send_sample(1, 1'b0);
        send_sample(0, 1'b1);
    endtask

    // Random sequences of several shapes, with random window sizes and idling.
    task automatic test_random_sequences();
        logic [CFG_W-1:0]           code;
        logic signed [SAMPLE_W-1:0] v;
        int unsigned                w;
        int unsigned                len;
        int unsigned                shape;
        int unsigned                r;
        logic                       ends;
        w = eff_window(window_reg);
        while (random_sent < RANDOM_ITEMS) begin
            // Now and then pick a new window, mostly small, sometimes full or out of range.
            if ($urandom_range(0, 2) == 0) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    code = 7'd0;
                end else if (r == 1) begin
                    code = CFG_W'($urandom_range(WIN_MAX + 1, 127));
                end else if (r == 2) begin
                    code = CFG_W'(WIN_MAX);
                end else if (r <= 4) begin
                    code = CFG_W'($urandom_range(9, WIN_MAX));
                end else begin
                    code = CFG_W'($urandom_range(1, 8));
                end
                write_window(code);
                w = eff_window(code);
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                len = $urandom_range(1, w);
            end else if (r == 1) begin
                len = w + $urandom_range(40, 80);
            end else begin
                len = w + $urandom_range(0, 16);
            end
            ends     = ($urandom_range(0, 7) != 0);
            shape    = $urandom_range(0, 3);
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            v        = $urandom;
            for (int i = 0; i < len; i++) begin
                case (shape)
                    0: begin
                        v = $urandom;
                    end
                    1: begin
                        v = int'($urandom_range(0, 6)) - 3;
                    end
                    2: begin
                        // Slowly falling values fill the queue deeply.
                        v = v - int'($urandom_range(0, 2));
                    end
                    default: begin
                        r = $urandom_range(0, 4);
                        v = (r == 0) ? 32'sh7FFFFFFF : (r == 1) ? 32'sh80000000 :
                            (r == 2) ? 0 : (r == 3) ? -1 : $urandom;
                    end
                endcase
                send_sample(v, ends && (i == len - 1));
                random_sent++;
            end
            // Occasionally let every outstanding result through before going on.
            if ($urandom_range(0, 7) == 0) begin
                wait_results_drained();
            end
        end
        idle_max = 8;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_window();
        test_equal_values();
        test_short_sequence();
        test_window_limits();
        test_resize_midsequence();
        test_random_sequences();
        i_in_valid <= 1'b0;
        while (expected_max_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
